// ----- design/pmpi_pkg.sv -----
package pmpi_pkg;

    localparam int unsigned STATUS_W = 8;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DELTA_W  = 16;
    localparam int unsigned BTN_W    = 3;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned SCREEN_W = 13;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 13;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PS2_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

    localparam logic ACT_PS2   = 1'b0;
    localparam logic ACT_DELTA = 1'b1;

    localparam int unsigned ST_DATA_READY = 0;
    localparam int unsigned ST_AUX        = 5;

    localparam int unsigned HDR_SYNC   = 3;
    localparam int unsigned HDR_X_SIGN = 4;
    localparam int unsigned HDR_Y_SIGN = 5;
    localparam int unsigned HDR_X_OVF  = 6;
    localparam int unsigned HDR_Y_OVF  = 7;

    localparam logic [POS_W-1:0]    POS_X_RESET  = 12'd160;
    localparam logic [POS_W-1:0]    POS_Y_RESET  = 12'd100;
    localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 13'd320;
    localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 13'd200;
    localparam logic [POS_W-1:0]    POS_MAX      = 12'd4095;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2
    } phase_t;

endpackage

// ----- design/pmpi_clamp.sv -----
module pmpi_clamp #(
    parameter int unsigned CURSOR_SIZE = 3
) (
    input  logic [pmpi_pkg::POS_W-1:0]           pos,
    input  logic signed [pmpi_pkg::DELTA_W-1:0]  delta,
    input  logic [pmpi_pkg::SCREEN_W-1:0]        screen,
    output logic [pmpi_pkg::POS_W-1:0]           pos_new
);
    import pmpi_pkg::*;

    localparam int unsigned LIM_W = SCREEN_W + 1;
    localparam int unsigned SUM_W = DELTA_W + 2;
    localparam logic signed [LIM_W-1:0] CURSOR = LIM_W'(CURSOR_SIZE);

    logic signed [LIM_W-1:0] limit_raw;
    logic [POS_W-1:0]        limit;
    logic signed [SUM_W-1:0] sum;

    always_comb begin
        limit_raw = $signed({1'b0, screen}) - CURSOR;
        if (limit_raw < 0) begin
            limit = '0;
        end else if (limit_raw > $signed({2'b00, POS_MAX})) begin
            limit = POS_MAX;
        end else begin
            limit = limit_raw[POS_W-1:0];
        end

        sum = $signed({{(SUM_W-POS_W){1'b0}}, pos}) + SUM_W'(delta);
        if (sum < 0) begin
            pos_new = '0;
        end else if (sum > $signed({{(SUM_W-POS_W){1'b0}}, limit})) begin
            pos_new = limit;
        end else begin
            pos_new = sum[POS_W-1:0];
        end
    end

endmodule

// ----- design/ps2_mouse_packet_integrator_unit.sv -----
// Channel  | Ports                       | Contents (lowest bit up)
// s_ input | s_tvalid s_tready s_tdata   | tdata: ctrl_status, aux_byte, delta_x, delta_y,
//          | s_tuser                     |   buttons_in; tuser: action
// m_ out   | m_tvalid m_tready m_tdata   | tdata: pos_x, pos_y, buttons, ready_res;
//          | m_tuser                     |   tuser: updated
// cfg      | cfg_wr_en cfg_index cfg_wdata | 0 ps2_enable, 1 screen_width, 2 screen_height
//
// One item a cycle while results are taken: an item is taken into the input register,
// and its result is then registered in the result register; the clamp adders set the path.
// Reset (aresetn low, synchronous) clears the assembler, centres the pointer and
// loads the default screen size. A stalled result holds the input register full,
// after which s_tready falls until the result transfer completes.
module ps2_mouse_packet_integrator_unit #(
    parameter int unsigned CURSOR_SIZE = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // ctrl_status, aux_byte, delta_x, delta_y, buttons_in, zero fill
    input  logic [pmpi_pkg::S_TDATA_W-1:0]     s_tdata,
    // action
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pos_x, pos_y, buttons, ready_res, zero fill
    output logic [pmpi_pkg::M_TDATA_W-1:0]     m_tdata,
    // updated
    output logic                               m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [pmpi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pmpi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import pmpi_pkg::*;

    logic                       ps2_enable_reg;
    logic [SCREEN_W-1:0]        screen_width_reg;
    logic [SCREEN_W-1:0]        screen_height_reg;

    logic                       in_valid_reg;
    logic                       in_action_reg;
    logic [STATUS_W-1:0]        in_status_reg;
    logic [BYTE_W-1:0]          in_byte_reg;
    logic signed [DELTA_W-1:0]  in_dx_reg;
    logic signed [DELTA_W-1:0]  in_dy_reg;
    logic [BTN_W-1:0]           in_btn_reg;

    phase_t                     phase_reg, phase_next;
    logic [BYTE_W-1:0]          header_reg, header_next;
    logic [BYTE_W-1:0]          x_byte_reg, x_byte_next;
    logic [POS_W-1:0]           cursor_x_reg, cursor_y_reg;
    logic [BTN_W-1:0]           buttons_reg, buttons_next;
    logic                       seen_reg;
    logic                       out_valid_reg;
    logic                       updated_reg, updated_next;

    logic                       advance;
    logic                       take;
    logic                       ps2_ok;
    logic                       ps2_done;
    logic                       sample;
    logic signed [DELTA_W-1:0]  dx, dy;
    logic signed [9:0]          ps2_dx, ps2_dy;
    logic [POS_W-1:0]           cursor_x_new, cursor_y_new;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign take     = in_valid_reg && advance;

    assign ps2_ok = (in_action_reg == ACT_PS2) && ps2_enable_reg
                    && in_status_reg[ST_DATA_READY] && in_status_reg[ST_AUX];

    always_comb begin
        phase_next = phase_reg;
        if (ps2_ok) begin
            case (phase_reg)
                PH_X:    phase_next = PH_Y;
                PH_Y:    phase_next = PH_HEADER;
                default: phase_next = in_byte_reg[HDR_SYNC] ? PH_X : PH_HEADER;
            endcase
        end
    end

    always_comb begin
        header_next = header_reg;
        x_byte_next = x_byte_reg;
        ps2_done    = 1'b0;
        if (ps2_ok) begin
            case (phase_reg)
                PH_X:    x_byte_next = in_byte_reg;
                PH_Y:    ps2_done = 1'b1;
                default: begin
                    if (in_byte_reg[HDR_SYNC]) begin
                        header_next = in_byte_reg;
                    end
                end
            endcase
        end
    end

    always_comb begin
        ps2_dx = $signed({{2{header_reg[HDR_X_SIGN]}},
                          header_reg[HDR_X_OVF] ? {BYTE_W{1'b0}} : x_byte_reg});
        ps2_dy = $signed({{2{header_reg[HDR_Y_SIGN]}},
                          header_reg[HDR_Y_OVF] ? {BYTE_W{1'b0}} : in_byte_reg});
        if (in_action_reg == ACT_DELTA) begin
            dx           = in_dx_reg;
            dy           = in_dy_reg;
            buttons_next = in_btn_reg;
        end else begin
            dx           = DELTA_W'(ps2_dx);
            dy           = -DELTA_W'(ps2_dy);
            buttons_next = header_reg[BTN_W-1:0];
        end
        sample       = (in_action_reg == ACT_DELTA) || ps2_done;
        updated_next = sample;
    end

    pmpi_clamp #(
        .CURSOR_SIZE (CURSOR_SIZE)
    ) u_clamp_x (
        .pos     (cursor_x_reg),
        .delta   (dx),
        .screen  (screen_width_reg),
        .pos_new (cursor_x_new)
    );

    pmpi_clamp #(
        .CURSOR_SIZE (CURSOR_SIZE)
    ) u_clamp_y (
        .pos     (cursor_y_reg),
        .delta   (dy),
        .screen  (screen_height_reg),
        .pos_new (cursor_y_new)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps2_enable_reg    <= 1'b1;
            screen_width_reg  <= WIDTH_RESET;
            screen_height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PS2_ENABLE:    ps2_enable_reg    <= cfg_wdata[0];
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_status_reg <= s_tdata[7:0];
            in_byte_reg   <= s_tdata[15:8];
            in_dx_reg     <= s_tdata[31:16];
            in_dy_reg     <= s_tdata[47:32];
            in_btn_reg    <= s_tdata[50:48];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            header_reg    <= '0;
            x_byte_reg    <= '0;
            cursor_x_reg  <= POS_X_RESET;
            cursor_y_reg  <= POS_Y_RESET;
            buttons_reg   <= '0;
            seen_reg      <= 1'b0;
            updated_reg   <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (take) begin
                phase_reg   <= phase_next;
                header_reg  <= header_next;
                x_byte_reg  <= x_byte_next;
                updated_reg <= updated_next;
                if (sample) begin
                    cursor_x_reg <= cursor_x_new;
                    cursor_y_reg <= cursor_y_new;
                    buttons_reg  <= buttons_next;
                    seen_reg     <= 1'b1;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2*POS_W-BTN_W-1){1'b0}},
                       seen_reg, buttons_reg, cursor_y_reg, cursor_x_reg};
    assign m_tuser  = updated_reg;

endmodule

// ----- dv/ps2_mouse_packet_integrator_checker.sv -----
`timescale 1ns / 1ps

module ps2_mouse_packet_integrator_checker #(
    parameter int unsigned CURSOR_SIZE = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [pmpi_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [pmpi_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [pmpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmpi_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              mismatches,
    output int                              outstanding
);
    import pmpi_pkg::*;

    typedef struct packed {
        logic [4:0]         pad;
        logic [BTN_W-1:0]   buttons_in;
        logic [DELTA_W-1:0] delta_y;
        logic [DELTA_W-1:0] delta_x;
        logic [BYTE_W-1:0]  aux_byte;
        logic [STATUS_W-1:0] ctrl_status;
    } motion_item_t;

    typedef struct packed {
        logic             updated;
        logic             ready_res;
        logic [BTN_W-1:0] buttons;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
    } pointer_result_t;

    pointer_result_t pointer_q[$];

    logic                ps2_en;
    logic [SCREEN_W-1:0] scr_w;
    logic [SCREEN_W-1:0] scr_h;

    phase_t              asm_phase;
    logic [BYTE_W-1:0]   hdr_byte;
    logic [BYTE_W-1:0]   x_byte;
    logic [POS_W-1:0]    cur_x;
    logic [POS_W-1:0]    cur_y;
    logic [BTN_W-1:0]    btn_bits;
    logic                seen;

    function automatic logic [POS_W-1:0] clamp_axis(logic [POS_W-1:0] pos, int delta,
                                                    logic [SCREEN_W-1:0] screen);
        int limit;
        int v;
        limit = int'(screen) - int'(CURSOR_SIZE);
        v = int'(pos) + delta;
        if (limit < 0) limit = 0;
        if (limit > int'(POS_MAX)) limit = int'(POS_MAX);
        if (v < 0) v = 0;
        if (v > limit) v = limit;
        return v[POS_W-1:0];
    endfunction

    task automatic integrate_motion(int dx, int dy, logic [BTN_W-1:0] btn);
        cur_x = clamp_axis(cur_x, dx, scr_w);
        cur_y = clamp_axis(cur_y, dy, scr_h);
        btn_bits = btn;
        seen = 1'b1;
    endtask

    task automatic assemble_byte(logic [STATUS_W-1:0] status, logic [BYTE_W-1:0] data,
                                 output logic done);
        int dx;
        int dy;
        done = 1'b0;
        if (!ps2_en || !status[ST_DATA_READY] || !status[ST_AUX]) return;
        case (asm_phase)
            PH_X: begin
                x_byte = data;
                asm_phase = PH_Y;
            end
            PH_Y: begin
                dx = int'(x_byte);
                dy = int'(data);
                if (hdr_byte[HDR_X_OVF]) dx = 0;
                if (hdr_byte[HDR_Y_OVF]) dy = 0;
                if (hdr_byte[HDR_X_SIGN]) dx -= 256;
                if (hdr_byte[HDR_Y_SIGN]) dy -= 256;
                integrate_motion(dx, -dy, hdr_byte[BTN_W-1:0]);
                asm_phase = PH_HEADER;
                done = 1'b1;
            end
            default: begin
                if (!data[HDR_SYNC]) begin
                    asm_phase = PH_HEADER;
                end else begin
                    hdr_byte = data;
                    asm_phase = PH_X;
                end
            end
        endcase
    endtask

    function automatic int field_check(string name, int unsigned want, int unsigned got);
        if (want == got) return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        motion_item_t    item;
        pointer_result_t want;
        pointer_result_t got;
        logic            done;
        if (!aresetn) begin
            ps2_en      = 1'b1;
            scr_w       = WIDTH_RESET;
            scr_h       = HEIGHT_RESET;
            asm_phase   = PH_HEADER;
            hdr_byte    = '0;
            x_byte      = '0;
            cur_x       = POS_X_RESET;
            cur_y       = POS_Y_RESET;
            btn_bits    = '0;
            seen        = 1'b0;
            mismatches  = 0;
            pointer_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PS2_ENABLE:    ps2_en = cfg_wdata[0];
                    CFG_SCREEN_WIDTH:  scr_w  = cfg_wdata;
                    CFG_SCREEN_HEIGHT: scr_h  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                item = motion_item_t'(s_tdata);
                if (s_tuser == ACT_DELTA) begin
                    integrate_motion(int'($signed(item.delta_x)), int'($signed(item.delta_y)),
                                     item.buttons_in);
                    done = 1'b1;
                end else begin
                    assemble_byte(item.ctrl_status, item.aux_byte, done);
                end
                want.pos_x     = cur_x;
                want.pos_y     = cur_y;
                want.buttons   = btn_bits;
                want.ready_res = seen;
                want.updated   = done;
                pointer_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.pos_x     = m_tdata[POS_W-1:0];
                got.pos_y     = m_tdata[2*POS_W-1:POS_W];
                got.buttons   = m_tdata[2*POS_W+BTN_W-1:2*POS_W];
                got.ready_res = m_tdata[2*POS_W+BTN_W];
                got.updated   = m_tuser;
                if (pointer_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = pointer_q.pop_front();
                    mismatches += field_check("pos_x", want.pos_x, got.pos_x);
                    mismatches += field_check("pos_y", want.pos_y, got.pos_y);
                    mismatches += field_check("buttons", want.buttons, got.buttons);
                    mismatches += field_check("ready_res", want.ready_res, got.ready_res);
                    mismatches += field_check("updated", want.updated, got.updated);
                end
            end
        end
        outstanding = pointer_q.size();
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import pmpi_pkg::*;

    localparam int unsigned CURSOR = 3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int pending_results;
    int sent = 0;
    bit steady = 1'b0;

    ps2_mouse_packet_integrator_unit #(.CURSOR_SIZE(CURSOR)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    ps2_mouse_packet_integrator_checker #(.CURSOR_SIZE(CURSOR)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .mismatches(mismatch_count), .outstanding(pending_results)
    );

    always #10 aclk = ~aclk;

    function automatic int gap_cycles();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [STATUS_W-1:0] aux_status();
        logic [STATUS_W-1:0] st;
        st = STATUS_W'($urandom);
        st[ST_DATA_READY] = 1'b1;
        st[ST_AUX] = 1'b1;
        return st;
    endfunction

    function automatic logic [DELTA_W-1:0] rand_delta();
        case ($urandom_range(0, 4))
            0, 1: return 16'($urandom_range(0, 31)) - 16'd16;
            2:    return 16'($urandom_range(0, 2047)) - 16'd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic action, logic [STATUS_W-1:0] status,
                             logic [BYTE_W-1:0] data, logic [DELTA_W-1:0] dx,
                             logic [DELTA_W-1:0] dy, logic [BTN_W-1:0] btn);
        int gap;
        s_tdata  <= {5'b0, btn, dy, dx, data, status};
        s_tuser  <= action;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        gap = gap_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_ps2(logic [STATUS_W-1:0] status, logic [BYTE_W-1:0] data);
        send_item(ACT_PS2, status, data, 16'($urandom), 16'($urandom), 3'($urandom));
    endtask

    task automatic send_delta(logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy,
                              logic [BTN_W-1:0] btn);
        send_item(ACT_DELTA, 8'($urandom), 8'($urandom), dx, dy, btn);
    endtask

    task automatic send_packet();
        logic [BYTE_W-1:0] hdr;
        hdr = BYTE_W'($urandom);
        hdr[HDR_SYNC] = 1'b1;
        if ($urandom_range(0, 7) != 0) begin
            hdr[HDR_X_OVF] = 1'b0;
            hdr[HDR_Y_OVF] = 1'b0;
        end
        send_ps2(aux_status(), hdr);
        if ($urandom_range(0, 9) == 0) send_ps2(8'($urandom) & 8'hDE, 8'($urandom));
        send_ps2(aux_status(), 8'($urandom));
        // truncate now and then so the assembler has to resync
        if ($urandom_range(0, 9) != 0) send_ps2(aux_status(), 8'($urandom));
    endtask

    task automatic flush_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_screen();
        if ($urandom_range(0, 2) == 0) return 13'($urandom_range(4, 40));
        return 13'($urandom_range(4, 4096));
    endfunction

    initial begin : result_sink
        int run;
        int hold;
        forever begin
            run = steady ? 50 : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            hold = steady ? 0 : gap_cycles();
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int target;
        int r;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_delta(16'h7FFF, 16'h7FFF, 3'b111);
        send_delta(16'h8000, 16'h8000, 3'b000);
        send_ps2(8'h20, 8'h08);
        send_ps2(8'h01, 8'h08);
        send_ps2(8'h21, 8'hF7);
        send_ps2(8'h21, 8'h09);
        send_ps2(8'h21, 8'h7F);
        send_ps2(8'h21, 8'h10);
        send_ps2(8'hFF, 8'h3A);
        send_ps2(8'hDE, 8'h00);
        send_ps2(8'hFF, 8'h00);
        send_ps2(8'hFF, 8'h00);
        send_ps2(8'h21, 8'hCF);
        send_ps2(8'h21, 8'hFF);
        send_ps2(8'h21, 8'hFF);
        send_ps2(8'h21, 8'hFC);
        send_ps2(8'h21, 8'h80);
        send_ps2(8'h21, 8'h01);
        flush_results();
        write_reg(CFG_PS2_ENABLE, 13'd0);
        send_ps2(8'h21, 8'h0F);
        send_ps2(8'h21, 8'h40);
        send_ps2(8'h21, 8'h40);
        send_delta(16'h0001, 16'hFFFF, 3'b101);

        for (int p = 0; p < 6; p++) begin
            flush_results();
            case (p)
                0: begin
                    write_reg(CFG_PS2_ENABLE, 13'd1);
                    write_reg(CFG_SCREEN_WIDTH, 13'd4096);
                    write_reg(CFG_SCREEN_HEIGHT, 13'd4096);
                end
                1: begin
                    write_reg(CFG_SCREEN_WIDTH, 13'd4);
                    write_reg(CFG_SCREEN_HEIGHT, 13'd4);
                end
                2: begin
                    write_reg(CFG_PS2_ENABLE, 13'd0);
                    write_reg(CFG_SCREEN_WIDTH, rand_screen());
                    write_reg(CFG_SCREEN_HEIGHT, rand_screen());
                end
                default: begin
                    write_reg(CFG_PS2_ENABLE, 13'd1);
                    write_reg(CFG_SCREEN_WIDTH, rand_screen());
                    write_reg(CFG_SCREEN_HEIGHT, rand_screen());
                end
            endcase
            steady = (p == 3);
            target = sent + 125;
            while (sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 60) send_packet();
                else if (r < 80) send_delta(rand_delta(), rand_delta(), 3'($urandom));
                else send_ps2(8'($urandom), 8'($urandom));
            end
        end

        flush_results();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
